### hdl/imad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imad_pkg
// Shared types, codes and tables for the stereo IMA ADPCM decoder.
// ----------------------------------------------------------------------------
package imad_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned IndexW  = 7;
  localparam int unsigned OffsetW = 31;
  localparam int unsigned StepW   = 15;

  localparam logic [IndexW-1:0] IDX_MAX = 7'd88;

  typedef enum logic [1:0] {
    KIND_DECODE  = 2'd0,
    KIND_RESTORE = 2'd1,
    KIND_RESTART = 2'd2,
    KIND_UNUSED  = 2'd3
  } kind_e;

  // one command from the input stage to the channel state
  typedef struct packed {
    logic  fire;
    kind_e kind;
  } imad_cmd_t;

  typedef struct packed {
    logic signed [SampleW-1:0] left_first;
    logic signed [SampleW-1:0] right_first;
    logic signed [SampleW-1:0] left_second;
    logic signed [SampleW-1:0] right_second;
  } imad_samples_t;

  function automatic logic signed [7:0] adj_of(input logic [2:0] c);
    logic signed [7:0] a;
    case (c)
      3'd4:    a = 8'sd2;
      3'd5:    a = 8'sd4;
      3'd6:    a = 8'sd6;
      3'd7:    a = 8'sd8;
      default: a = -8'sd1;
    endcase
    return a;
  endfunction

  function automatic logic [StepW-1:0] step_of(input logic [IndexW-1:0] i);
    logic [StepW-1:0] s;
    case (i)
      7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
      7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
      7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
      7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
      7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
      7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
      7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
      7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
      7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
      7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
      7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
      7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
      7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
      7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
      7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
      7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
      7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
      7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
      7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
      7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
      7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
      7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
      7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
      7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
      7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
      7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
      7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
      7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
      7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
      7'd87: s = 15'd29794;
      default: s = 15'd32767;
    endcase
    return s;
  endfunction

endpackage

### hdl/ima_adpcm_stereo_interleaved_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ima_adpcm_stereo_interleaved_decoder
// Stereo 4-bit IMA ADPCM decoder with loop point save and restore.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       sink       in_valid_i/stall_o   kind_i, left_byte_i, right_byte_i
//  out      source     out_valid_o/stall_i  left/right_first_o, _second_o
//  cfg      sink       cfg_valid_i/ready_o  cfg_data_i (loop point)
//
//  one item per cycle unless a stalled result holds a decode item
//  all four nibble steps for an item are combinational between the
//  input register and the result register, chained through the channel state
//  reset clears channel state, saved set and offset; loop point reads as -1
//  a stalled result holds the decode stage only for decode items
// ----------------------------------------------------------------------------
module ima_adpcm_stereo_interleaved_decoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        kind_i,
  input  logic [7:0]                        left_byte_i,
  input  logic [7:0]                        right_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [imad_pkg::SampleW-1:0] left_first_o,
  output logic signed [imad_pkg::SampleW-1:0] right_first_o,
  output logic signed [imad_pkg::SampleW-1:0] left_second_o,
  output logic signed [imad_pkg::SampleW-1:0] right_second_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [imad_pkg::OffsetW-1:0]      cfg_data_i
);
  import imad_pkg::*;

  logic                 in_valid_q;
  kind_e                kind_q;
  logic [7:0]           left_q, right_q;
  logic [OffsetW-1:0]   loop_point_q;
  logic                 out_valid_q;
  imad_samples_t        res_q;
  imad_samples_t        samples;
  imad_cmd_t            cmd;
  logic                 out_free, advance, in_take, res_load;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_point_q <= '1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      loop_point_q <= cfg_data_i;
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && ((kind_q != KIND_DECODE) || out_free);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;
  assign res_load   = advance && (kind_q == KIND_DECODE);

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      kind_q  <= kind_e'(kind_i);
      left_q  <= left_byte_i;
      right_q <= right_byte_i;
    end
  end

  assign cmd.fire = advance;
  assign cmd.kind = kind_q;

  imad_state u_state (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .left_byte_i  (left_q),
    .right_byte_i (right_q),
    .loop_point_i (loop_point_q),
    .samples_o    (samples)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= samples;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign left_first_o   = res_q.left_first;
  assign right_first_o  = res_q.right_first;
  assign left_second_o  = res_q.left_second;
  assign right_second_o = res_q.right_second;

  a_stall_only_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && (kind_q == KIND_DECODE) && out_valid_q)
    else $error("input stalled without a blocked decode");

  a_decode_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> out_valid_q)
    else $error("decode transfer produced no result");

  a_control_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (kind_q != KIND_DECODE) && out_valid_q && out_stall_i |=> out_valid_q)
    else $error("control item disturbed a pending result");

endmodule

### hdl/imad_nibble.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imad_nibble
// One ADPCM nibble step: difference, saturating predictor update, index adjust.
// ----------------------------------------------------------------------------
module imad_nibble (
  input  logic signed [imad_pkg::SampleW-1:0] pred_i,
  input  logic        [imad_pkg::IndexW-1:0]  idx_i,
  input  logic        [3:0]                   code_i,
  output logic signed [imad_pkg::SampleW-1:0] pred_o,
  output logic        [imad_pkg::IndexW-1:0]  idx_o
);
  import imad_pkg::*;

  logic        [IndexW-1:0] idx_c;
  logic        [StepW-1:0]  step;
  logic        [18:0]       prod;
  logic        [15:0]       diff;
  logic signed [17:0]       pred_x;
  logic signed [17:0]       diff_x;
  logic signed [17:0]       sum;
  logic signed [7:0]        ni;

  assign idx_c = (idx_i > IDX_MAX) ? IDX_MAX : idx_i;
  assign step  = step_of(idx_c);

  // (2c+1)*step as shift-and-add
  assign prod = {4'b0, step}
              + (code_i[0] ? {3'b0, step, 1'b0} : 19'd0)
              + (code_i[1] ? {2'b0, step, 2'b0} : 19'd0)
              + (code_i[2] ? {1'b0, step, 3'b0} : 19'd0);
  assign diff = prod[18:3];

  assign pred_x = {{2{pred_i[SampleW-1]}}, pred_i};
  assign diff_x = $signed({2'b0, diff});
  assign sum    = code_i[3] ? (pred_x - diff_x) : (pred_x + diff_x);

  always_comb begin
    if (sum > 18'sd32767) begin
      pred_o = 16'sh7fff;
    end else if (sum < -18'sd32768) begin
      pred_o = 16'sh8000;
    end else begin
      pred_o = sum[15:0];
    end
  end

  assign ni = $signed({1'b0, idx_c}) + adj_of(code_i[2:0]);

  always_comb begin
    if (ni < 8'sd0) begin
      idx_o = '0;
    end else if (ni > $signed({1'b0, IDX_MAX})) begin
      idx_o = IDX_MAX;
    end else begin
      idx_o = ni[IndexW-1:0];
    end
  end

endmodule

### hdl/imad_state.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imad_state
// Channel state, loop save set and byte offset, with the four nibble steps.
// ----------------------------------------------------------------------------
module imad_state (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  imad_pkg::imad_cmd_t              cmd_i,
  input  logic [7:0]                       left_byte_i,
  input  logic [7:0]                       right_byte_i,
  input  logic [imad_pkg::OffsetW-1:0]     loop_point_i,
  output imad_pkg::imad_samples_t          samples_o
);
  import imad_pkg::*;

  logic signed [SampleW-1:0] lp_q, rp_q, slp_q, srp_q;
  logic        [IndexW-1:0]  li_q, ri_q, sli_q, sri_q;
  logic        [OffsetW-1:0] offset_q;

  logic signed [SampleW-1:0] lp1, rp1, lp2, rp2;
  logic        [IndexW-1:0]  li1, ri1, li2, ri2;
  logic                      is_decode, do_save;

  imad_nibble u_left_first (
    .pred_i(lp_q), .idx_i(li_q), .code_i(left_byte_i[3:0]),
    .pred_o(lp1),  .idx_o(li1)
  );
  imad_nibble u_right_first (
    .pred_i(rp_q), .idx_i(ri_q), .code_i(right_byte_i[3:0]),
    .pred_o(rp1),  .idx_o(ri1)
  );
  imad_nibble u_left_second (
    .pred_i(lp1), .idx_i(li1), .code_i(left_byte_i[7:4]),
    .pred_o(lp2), .idx_o(li2)
  );
  imad_nibble u_right_second (
    .pred_i(rp1), .idx_i(ri1), .code_i(right_byte_i[7:4]),
    .pred_o(rp2), .idx_o(ri2)
  );

  assign samples_o.left_first   = lp1;
  assign samples_o.right_first  = rp1;
  assign samples_o.left_second  = lp2;
  assign samples_o.right_second = rp2;

  assign is_decode = cmd_i.fire && (cmd_i.kind == KIND_DECODE);
  // negative loop point disables the save
  assign do_save   = is_decode && !loop_point_i[OffsetW-1] && (offset_q == loop_point_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_q     <= '0;
      rp_q     <= '0;
      li_q     <= '0;
      ri_q     <= '0;
      slp_q    <= '0;
      srp_q    <= '0;
      sli_q    <= '0;
      sri_q    <= '0;
      offset_q <= '0;
    end else begin
      if (do_save) begin
        slp_q <= lp_q;
        srp_q <= rp_q;
        sli_q <= li_q;
        sri_q <= ri_q;
      end
      if (cmd_i.fire) begin
        case (cmd_i.kind)
          KIND_DECODE: begin
            lp_q     <= lp2;
            rp_q     <= rp2;
            li_q     <= li2;
            ri_q     <= ri2;
            offset_q <= offset_q + OffsetW'(2);
          end
          KIND_RESTORE: begin
            lp_q     <= slp_q;
            rp_q     <= srp_q;
            li_q     <= sli_q;
            ri_q     <= sri_q;
            offset_q <= loop_point_i;
          end
          KIND_RESTART: begin
            lp_q     <= '0;
            rp_q     <= '0;
            li_q     <= '0;
            ri_q     <= '0;
            offset_q <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (li_q <= IDX_MAX) && (ri_q <= IDX_MAX) && (sli_q <= IDX_MAX) && (sri_q <= IDX_MAX))
    else $error("step index beyond table");

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fire && (cmd_i.kind == KIND_RESTART)
    |=> (lp_q == '0) && (rp_q == '0) && (li_q == '0) && (ri_q == '0) && (offset_q == '0))
    else $error("restart left channel state behind");

endmodule

### tb/imad_sample_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imad_sample_checker
// Follows every transfer on the input, result and loop point channels, keeps
// its own copy of both channel states and the saved loop state, and compares
// each result with the oldest predicted set of four samples.
// ----------------------------------------------------------------------------
module imad_sample_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic                                 in_stall_i,
  input  logic [1:0]                           kind_i,
  input  logic [7:0]                           left_byte_i,
  input  logic [7:0]                           right_byte_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_stall_i,
  input  logic signed [imad_pkg::SampleW-1:0]  left_first_i,
  input  logic signed [imad_pkg::SampleW-1:0]  right_first_i,
  input  logic signed [imad_pkg::SampleW-1:0]  left_second_i,
  input  logic signed [imad_pkg::SampleW-1:0]  right_second_i,
  input  logic                                 cfg_valid_i,
  input  logic                                 cfg_ready_i,
  input  logic [imad_pkg::OffsetW-1:0]         cfg_data_i,
  output int                                   pending_o,
  output int                                   fail_count_o
);
  import imad_pkg::*;

  int step_size [0:88] = '{
    7, 8, 9, 10, 11, 12, 13, 14, 16, 17, 19, 21, 23, 25, 28, 31, 34, 37, 41,
    45, 50, 55, 60, 66, 73, 80, 88, 97, 107, 118, 130, 143, 157, 173, 190,
    209, 230, 253, 279, 307, 337, 371, 408, 449, 494, 544, 598, 658, 724,
    796, 876, 963, 1060, 1166, 1282, 1411, 1552, 1707, 1878, 2066, 2272,
    2499, 2749, 3024, 3327, 3660, 4026, 4428, 4871, 5358, 5894, 6484, 7132,
    7845, 8630, 9493, 10442, 11487, 12635, 13899, 15289, 16818, 18500,
    20350, 22385, 24623, 27086, 29794, 32767
  };

  logic [OffsetW-1:0]        loop_point;
  logic [OffsetW-1:0]        byte_offset;
  logic signed [SampleW-1:0] left_pred, right_pred;
  logic signed [SampleW-1:0] saved_left_pred, saved_right_pred;
  logic [IndexW-1:0]         left_idx, right_idx;
  logic [IndexW-1:0]         saved_left_idx, saved_right_idx;
  imad_samples_t             expected_q [$];
  int                        mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic decode_nibble(inout logic signed [SampleW-1:0] pred,
                               inout logic [IndexW-1:0] idx,
                               input logic [3:0] nib,
                               output logic signed [SampleW-1:0] sample);
    int i, mag, diff, acc, next_idx;
    i    = (idx > IDX_MAX) ? int'(IDX_MAX) : int'(idx);
    mag  = int'(nib[2:0]);
    diff = ((2 * mag + 1) * step_size[i]) >>> 3;
    acc  = int'(pred);
    if (nib[3]) begin
      acc = acc - diff;
      if (acc < -32768) acc = -32768;
    end else begin
      acc = acc + diff;
      if (acc > 32767) acc = 32767;
    end
    // adjust table: -1 for magnitudes 0..3, then 2, 4, 6, 8
    next_idx = i + ((mag < 4) ? -1 : 2 * (mag - 3));
    if (next_idx < 0) next_idx = 0;
    if (next_idx > int'(IDX_MAX)) next_idx = int'(IDX_MAX);
    pred   = acc[SampleW-1:0];
    idx    = next_idx[IndexW-1:0];
    sample = pred;
  endtask

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  task automatic compare_sample(input string field, input logic signed [SampleW-1:0] want,
                                input logic signed [SampleW-1:0] got);
    if (got !== want)
      report($sformatf("%s mismatch: expected %0d, got %0d", field, want, got));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    imad_samples_t want;
    if (!rst_ni) begin
      loop_point       = '1;
      byte_offset      = '0;
      left_pred        = '0;
      right_pred       = '0;
      left_idx         = '0;
      right_idx        = '0;
      saved_left_pred  = '0;
      saved_right_pred = '0;
      saved_left_idx   = '0;
      saved_right_idx  = '0;
      expected_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) loop_point = cfg_data_i;

      // results leave before the item accepted in this cycle could produce one
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report($sformatf("result transfer with nothing expected: %0d %0d %0d %0d",
                           left_first_i, right_first_i, left_second_i, right_second_i));
        end else begin
          want = expected_q.pop_front();
          compare_sample("left_first", want.left_first, left_first_i);
          compare_sample("right_first", want.right_first, right_first_i);
          compare_sample("left_second", want.left_second, left_second_i);
          compare_sample("right_second", want.right_second, right_second_i);
        end
      end

      if (in_valid_i && !in_stall_i) begin
        case (kind_i)
          KIND_RESTORE: begin
            left_pred   = saved_left_pred;
            right_pred  = saved_right_pred;
            left_idx    = saved_left_idx;
            right_idx   = saved_right_idx;
            byte_offset = loop_point;
          end
          KIND_RESTART: begin
            left_pred   = '0;
            right_pred  = '0;
            left_idx    = '0;
            right_idx   = '0;
            byte_offset = '0;
          end
          KIND_DECODE: begin
            // a negative loop point never matches
            if (!loop_point[OffsetW-1] && byte_offset == loop_point) begin
              saved_left_pred  = left_pred;
              saved_right_pred = right_pred;
              saved_left_idx   = left_idx;
              saved_right_idx  = right_idx;
            end
            byte_offset = byte_offset + OffsetW'(2);
            decode_nibble(left_pred, left_idx, left_byte_i[3:0], want.left_first);
            decode_nibble(right_pred, right_idx, right_byte_i[3:0], want.right_first);
            decode_nibble(left_pred, left_idx, left_byte_i[7:4], want.left_second);
            decode_nibble(right_pred, right_idx, right_byte_i[7:4], want.right_second);
            expected_q.push_back(want);
          end
          default: ;
        endcase
      end

      pending_o <= expected_q.size();
    end
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the stereo IMA ADPCM decoder with a directed run through saturation,
// loop save, restore, restart and the unused kind, then with random loop
// sequences under several loop point settings, random idling on both sides
// and one long result hold-off. Checking is done by imad_sample_checker.
// ----------------------------------------------------------------------------
module tb;
  import imad_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int HoldCycles = 300;
  localparam int PhaseItems = 305;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic [1:0]                kind_i;
  logic [7:0]                left_byte_i;
  logic [7:0]                right_byte_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic signed [SampleW-1:0] left_first_o;
  logic signed [SampleW-1:0] right_first_o;
  logic signed [SampleW-1:0] left_second_o;
  logic signed [SampleW-1:0] right_second_o;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [OffsetW-1:0]        cfg_data_i;

  int pending;
  int fail_count;
  int quiet_cycles = 0;
  bit tx_idle_on;
  bit rx_idle_on;
  bit hold_req;

  ima_adpcm_stereo_interleaved_decoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .left_byte_i    (left_byte_i),
    .right_byte_i   (right_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .left_first_o   (left_first_o),
    .right_first_o  (right_first_o),
    .left_second_o  (left_second_o),
    .right_second_o (right_second_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  imad_sample_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .kind_i         (kind_i),
    .left_byte_i    (left_byte_i),
    .right_byte_i   (right_byte_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .left_first_i   (left_first_o),
    .right_first_i  (right_first_o),
    .left_second_i  (left_second_o),
    .right_second_i (right_second_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .pending_o      (pending),
    .fail_count_o   (fail_count)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // result side: random stall per transfer, plus one long hold-off on request
  initial begin
    int gap;
    bit held;
    held        = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
      end
      gap = rx_idle_on ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic push_item(input kind_e kind, input logic [7:0] lb, input logic [7:0] rb);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= kind;
    left_byte_i  <= lb;
    right_byte_i <= rb;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic write_loop_point(input logic [OffsetW-1:0] value);
    while (pending != 0) @(negedge clk_i);
    // restore and restart give no result and may still be in flight
    repeat (6) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] extreme_byte();
    logic [7:0] b;
    case ($urandom_range(0, 5))
      0:       b = 8'h77;
      1:       b = 8'hff;
      2:       b = 8'h00;
      3:       b = 8'h88;
      4:       b = 8'h7f;
      default: b = 8'hf7;
    endcase
    return b;
  endfunction

  task automatic run_random(input int count, input bit with_hold);
    int         done;
    int         sent;
    int         pick;
    int         burst_left;
    logic [7:0] burst_l, burst_r;
    kind_e      kind;
    done       = 0;
    sent       = 0;
    burst_left = 0;
    burst_l    = '0;
    burst_r    = '0;
    while (done < count) begin
      // runs of one byte pair push the index to its ends and the sample into clipping
      if (burst_left == 0 && $urandom_range(0, 15) == 0) begin
        burst_left = $urandom_range(6, 24);
        burst_l    = extreme_byte();
        burst_r    = extreme_byte();
      end
      pick = $urandom_range(0, 99);
      if (pick < 3)       kind = KIND_UNUSED;
      else if (pick < 9)  kind = KIND_RESTORE;
      else if (pick < 14) kind = KIND_RESTART;
      else                kind = KIND_DECODE;
      if (burst_left > 0) begin
        push_item(kind, burst_l, burst_r);
        burst_left--;
      end else begin
        push_item(kind, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
      if (kind != KIND_UNUSED) done++;
      sent++;
      if (sent % 64 == 0) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
      end
      if (with_hold && done == count / 2) hold_req = 1'b1;
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    logic [OffsetW-1:0] phase_start [6];
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    kind_i       = KIND_DECODE;
    left_byte_i  = '0;
    right_byte_i = '0;
    cfg_valid_i  = 1'b0;
    cfg_data_i   = '0;
    tx_idle_on   = 1'b1;
    rx_idle_on   = 1'b1;
    hold_req     = 1'b0;

    phase_start[0] = '1;
    phase_start[1] = 31'd0;
    phase_start[2] = 31'h3fff_fffe;
    phase_start[3] = 31'($urandom_range(1, 100) * 2);
    phase_start[4] = 31'($urandom_range(0, 99) * 2 + 1);
    phase_start[5] = 31'($urandom_range(0, 1073741822));

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: save at offset zero, clip both ways, mixed signs, loop and clear
    write_loop_point(31'd0);
    push_item(KIND_DECODE, 8'h00, 8'h00);
    repeat (12) push_item(KIND_DECODE, 8'h77, 8'hff);
    push_item(KIND_DECODE, 8'h08, 8'h80);
    push_item(KIND_DECODE, 8'h88, 8'h07);
    push_item(KIND_RESTORE, 8'h00, 8'h00);
    push_item(KIND_DECODE, 8'h12, 8'h34);
    push_item(KIND_UNUSED, 8'hab, 8'hcd);
    push_item(KIND_DECODE, 8'hf7, 8'h7f);
    push_item(KIND_RESTART, 8'hff, 8'hff);
    push_item(KIND_DECODE, 8'hf0, 8'h0f);
    push_item(KIND_DECODE, 8'hff, 8'h77);
    in_valid_i <= 1'b0;

    foreach (phase_start[p]) begin
      write_loop_point(phase_start[p]);
      run_random(PhaseItems, p == 2);
    end

    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
